@@ rtl/tphr_pkg.sv @@
// Package: shared types and constants of the TCP port hop rewriter.
`default_nettype none
package tphr_pkg;

    localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
    localparam logic [7:0]  PROTO_TCP       = 8'd6;
    localparam logic [3:0]  IHL_MIN         = 4'd5;
    localparam logic [16:0] MIN_FRAME_BYTES = 17'd34;
    localparam logic [16:0] ETH_TCP_BYTES   = 17'd34;

    localparam int FIFO_DEPTH   = 4;
    localparam int RND_BITS     = 32;
    localparam int STEP_BITS    = 4;
    localparam int MOD_STAGES   = RND_BITS / STEP_BITS;
    localparam int CFG_IDX_BITS = 8;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_DST  = 2'd1,
        ACT_SRC  = 2'd2
    } t_action;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_CONFIG_VALID = 8'd0,
        REG_SERVICE_PORT = 8'd1,
        REG_HOP_MIN_PORT = 8'd2,
        REG_HOP_MAX_PORT = 8'd3
    } t_reg_idx;

    typedef struct packed {
        logic                hop;
        t_action             action;
        logic [15:0]         src;
        logic [15:0]         dst;
        logic [15:0]         csum;
        logic [15:0]         logged;
        logic [RND_BITS-1:0] rnd;
    } t_item;

    typedef struct packed {
        logic        valid;
        logic [15:0] service;
        logic [15:0] min;
        logic [15:0] max;
    } t_cfg;

endpackage
`default_nettype wire

@@ rtl/tphr_fifo.sv @@
// Short item queue between the classifier and the hop unit.
`default_nettype none
module tphr_fifo #(
    parameter int DEPTH = tphr_pkg::FIFO_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  tphr_pkg::t_item      i_data,
    input  wire logic            i_pop,
    output tphr_pkg::t_item      o_data,
    output logic                 o_full,
    output logic                 o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tphr_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule
`default_nettype wire

@@ rtl/tphr_front.sv @@
// Front stage: accepts headers, qualifies them and resolves ingress restores.
`default_nettype none
module tphr_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  tphr_pkg::t_cfg   i_cfg,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_mode,
    input  wire logic [15:0] i_frame_length,
    input  wire logic [15:0] i_ethertype,
    input  wire logic [3:0]  i_ip_header_words,
    input  wire logic [7:0]  i_ip_protocol,
    input  wire logic [15:0] i_src_port,
    input  wire logic [15:0] i_dst_port,
    input  wire logic [15:0] i_tcp_checksum,
    input  wire logic [31:0] i_random_value,
    input  wire logic        i_q_full,
    output logic             o_q_push,
    output tphr_pkg::t_item  o_q_data
);
    logic            r_valid;
    tphr_pkg::t_item r_item;
    tphr_pkg::t_item n_item;

    logic        ok, dst_in, src_in;
    logic [16:0] need;
    logic [15:0] old_port;
    logic [17:0] sum;
    logic [16:0] fold1;
    logic [15:0] fold2;

    assign o_in_stall = r_valid && i_q_full;
    assign o_q_push   = r_valid && !i_q_full;
    assign o_q_data   = r_item;

    always_comb begin
        need = tphr_pkg::ETH_TCP_BYTES + {11'd0, i_ip_header_words, 2'b00};
        ok = i_cfg.valid && (i_cfg.max > i_cfg.min)
            && (i_ethertype == tphr_pkg::ETHERTYPE_IPV4)
            && (i_ip_protocol == tphr_pkg::PROTO_TCP)
            && (i_ip_header_words >= tphr_pkg::IHL_MIN)
            && ({1'b0, i_frame_length} >= tphr_pkg::MIN_FRAME_BYTES)
            && ({1'b0, i_frame_length} >= need);
        dst_in = (i_dst_port >= i_cfg.min) && (i_dst_port < i_cfg.max);
        src_in = (i_src_port >= i_cfg.min) && (i_src_port < i_cfg.max);
        old_port = dst_in ? i_dst_port : i_src_port;
        sum = {2'b00, ~i_tcp_checksum} + {2'b00, ~old_port} + {2'b00, i_cfg.service};
        fold1 = {1'b0, sum[15:0]} + {15'd0, sum[17:16]};
        fold2 = fold1[15:0] + {15'd0, fold1[16]};

        n_item.hop    = 1'b0;
        n_item.action = tphr_pkg::ACT_NONE;
        n_item.src    = i_src_port;
        n_item.dst    = i_dst_port;
        n_item.csum   = i_tcp_checksum;
        n_item.logged = '0;
        n_item.rnd    = i_random_value;
        if (ok && !i_mode) begin
            if (i_dst_port == i_cfg.service) begin
                n_item.hop    = 1'b1;
                n_item.action = tphr_pkg::ACT_DST;
            end else if (i_src_port == i_cfg.service) begin
                n_item.hop    = 1'b1;
                n_item.action = tphr_pkg::ACT_SRC;
            end
        end else if (ok && (dst_in || src_in)) begin
            n_item.logged = old_port;
            n_item.csum   = ~fold2;
            if (dst_in) begin
                n_item.action = tphr_pkg::ACT_DST;
                n_item.dst    = i_cfg.service;
            end else begin
                n_item.action = tphr_pkg::ACT_SRC;
                n_item.src    = i_cfg.service;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_item <= n_item;
        end
    end
endmodule
`default_nettype wire

@@ rtl/tphr_back.sv @@
// Back end: pipelined hop port choice (random mod span) and result register.
`default_nettype none
module tphr_back (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [15:0] i_hop_min,
    input  wire logic [15:0] i_span,
    input  tphr_pkg::t_item  i_q_data,
    input  wire logic        i_q_empty,
    output logic             o_q_pop,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_action_taken,
    output logic [15:0]      o_out_src_port,
    output logic [15:0]      o_out_dst_port,
    output logic [15:0]      o_out_checksum,
    output logic [15:0]      o_logged_port
);
    localparam int NS = tphr_pkg::MOD_STAGES;
    localparam int SB = tphr_pkg::STEP_BITS;

    function automatic logic [15:0] f_mod_step(input logic [15:0] rem,
                                               input logic [SB-1:0] bits,
                                               input logic [15:0] span);
        logic [16:0] t;
        logic [15:0] r;
        r = rem;
        for (int b = SB - 1; b >= 0; b--) begin
            t = {r, bits[b]};
            if (t >= {1'b0, span}) begin
                t = t - {1'b0, span};
            end
            r = t[15:0];
        end
        return r;
    endfunction

    logic            r_pv  [NS];
    tphr_pkg::t_item r_pi  [NS];
    logic [15:0]     r_rem [NS];
    logic [15:0]     n_rem [NS];

    logic            r_o_valid;
    tphr_pkg::t_item r_o;
    tphr_pkg::t_item n_o;
    logic            adv;
    logic [15:0]     np;

    assign adv     = !r_o_valid || !i_out_stall;
    assign o_q_pop = adv && !i_q_empty;

    always_comb begin
        n_rem[0] = f_mod_step(16'd0, i_q_data.rnd[tphr_pkg::RND_BITS-1 -: SB], i_span);
        for (int s = 1; s < NS; s++) begin
            n_rem[s] = f_mod_step(r_rem[s-1],
                                  r_pi[s-1].rnd[tphr_pkg::RND_BITS-1-s*SB -: SB], i_span);
        end
    end

    always_comb begin
        np  = r_rem[NS-1] + i_hop_min;
        n_o = r_pi[NS-1];
        if (r_pi[NS-1].hop) begin
            n_o.logged = np;
            if (r_pi[NS-1].action == tphr_pkg::ACT_DST) begin
                n_o.dst = np;
            end else begin
                n_o.src = np;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) begin
                r_pv[s] <= 1'b0;
            end
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_pv[0] <= !i_q_empty;
            for (int s = 1; s < NS; s++) begin
                r_pv[s] <= r_pv[s-1];
            end
            r_o_valid <= r_pv[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pi[0]  <= i_q_data;
            r_rem[0] <= n_rem[0];
            for (int s = 1; s < NS; s++) begin
                r_pi[s]  <= r_pi[s-1];
                r_rem[s] <= n_rem[s];
            end
            r_o <= n_o;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_action_taken = r_o.action;
    assign o_out_src_port = r_o.src;
    assign o_out_dst_port = r_o.dst;
    assign o_out_checksum = r_o.csum;
    assign o_logged_port  = r_o.logged;
endmodule
`default_nettype wire

@@ rtl/tcp_port_hop_rewriter_top.sv @@
// Top level: configuration registers, classifier front, queue and hop back end.
// Path from input accept to result valid: front register, queue, modulo pipeline, result register.
// Throughput: one item per cycle when no stall holds the flow; the eight-stage modulo
// pipeline and a four-entry queue decouple the input stall from the output stall.
// Reset: synchronous active-low; clears control state and all configuration.
`default_nettype none
module tcp_port_hop_rewriter_top #(
    parameter int FIFO_DEPTH = tphr_pkg::FIFO_DEPTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [tphr_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [15:0]                       i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_mode,
    input  wire logic [15:0]                       i_frame_length,
    input  wire logic [15:0]                       i_ethertype,
    input  wire logic [3:0]                        i_ip_header_words,
    input  wire logic [7:0]                        i_ip_protocol,
    input  wire logic [15:0]                       i_src_port,
    input  wire logic [15:0]                       i_dst_port,
    input  wire logic [15:0]                       i_tcp_checksum,
    input  wire logic [31:0]                       i_random_value,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [1:0]                             o_action_taken,
    output logic [15:0]                            o_out_src_port,
    output logic [15:0]                            o_out_dst_port,
    output logic [15:0]                            o_out_checksum,
    output logic [15:0]                            o_logged_port
);
    tphr_pkg::t_cfg  r_cfg;
    tphr_pkg::t_item q_in, q_out;
    logic            q_push, q_pop, q_full, q_empty;
    logic [15:0]     span;

    assign o_cfg_ready = 1'b1;
    assign span        = r_cfg.max - r_cfg.min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tphr_pkg::REG_CONFIG_VALID: r_cfg.valid   <= i_cfg_data[0];
                tphr_pkg::REG_SERVICE_PORT: r_cfg.service <= i_cfg_data;
                tphr_pkg::REG_HOP_MIN_PORT: r_cfg.min     <= i_cfg_data;
                tphr_pkg::REG_HOP_MAX_PORT: r_cfg.max     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tphr_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_mode            (i_mode),
        .i_frame_length    (i_frame_length),
        .i_ethertype       (i_ethertype),
        .i_ip_header_words (i_ip_header_words),
        .i_ip_protocol     (i_ip_protocol),
        .i_src_port        (i_src_port),
        .i_dst_port        (i_dst_port),
        .i_tcp_checksum    (i_tcp_checksum),
        .i_random_value    (i_random_value),
        .i_q_full          (q_full),
        .o_q_push          (q_push),
        .o_q_data          (q_in)
    );

    tphr_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    tphr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_hop_min      (r_cfg.min),
        .i_span         (span),
        .i_q_data       (q_out),
        .i_q_empty      (q_empty),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_action_taken (o_action_taken),
        .o_out_src_port (o_out_src_port),
        .o_out_dst_port (o_out_dst_port),
        .o_out_checksum (o_out_checksum),
        .o_logged_port  (o_logged_port)
    );
endmodule
`default_nettype wire
